@@ hw/rtl/rgb_shade_via_hls_core_assert.svh @@
// Assertion macros shared by the checker of the RGB shade core.
`ifndef RGB_SHADE_VIA_HLS_CORE_ASSERT_SVH
`define RGB_SHADE_VIA_HLS_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent, outside reset.
`define SHV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shv assertion failed");

// Consequent checked in the cycle after the antecedent, outside reset.
`define SHV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shv assertion failed");

// Checked in the cycle after reset is seen, reset itself included.
`define SHV_ASSERT_AFTER_RST(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("shv reset assertion failed");

`endif

@@ hw/rtl/shv_pkg.sv @@
// Shared constants, codes and record types of the RGB shade core.
`default_nettype none
package shv_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CH_W       = 16;
  localparam int UNIT_W     = FRAC_BITS + 1;
  localparam int SHADE_W    = 16;
  localparam int SHADE_FRAC = 12;
  localparam int QUO_W      = 22;
  localparam int NUM_W      = 38;
  localparam int DIV_STEPS  = QUO_W;
  localparam int HUE_W      = 25;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [SHADE_W-1:0] SHADE_RESET = 16'd4096;
  localparam logic [UNIT_W-1:0]  ONE_Q  = UNIT_W'(1 << FRAC_BITS);
  localparam logic [UNIT_W-1:0]  HALF_Q = UNIT_W'(1 << (FRAC_BITS - 1));

  localparam logic [HUE_W-1:0] DEG_60  = HUE_W'(60 << FRAC_BITS);
  localparam logic [HUE_W-1:0] DEG_120 = HUE_W'(120 << FRAC_BITS);
  localparam logic [HUE_W-1:0] DEG_180 = HUE_W'(180 << FRAC_BITS);
  localparam logic [HUE_W-1:0] DEG_240 = HUE_W'(240 << FRAC_BITS);
  localparam logic [HUE_W-1:0] DEG_360 = HUE_W'(360 << FRAC_BITS);

  // Reciprocal of fifteen, exact for dividends below two to the 21.
  localparam logic [21:0] RECIP_15 = 22'd2236963;
  localparam int          RECIP_SH = 25;

  // Which channel holds the maximum.
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  typedef struct packed {
    logic [UNIT_W-1:0] l;
    logic              grey;
    logic [1:0]        sector;
    logic              neg;
    logic [NUM_W-1:0]  hnum;
    logic [UNIT_W-1:0] hdiv;
    logic [NUM_W-1:0]  snum;
    logic [UNIT_W-1:0] sdiv;
  } cls_t;

  typedef struct packed {
    logic [UNIT_W-1:0] l;
    logic              grey;
    logic [1:0]        sector;
    logic              neg;
    logic [QUO_W-1:0]  sq;
    logic [QUO_W-1:0]  hq;
  } dres_t;

endpackage
`default_nettype wire

@@ hw/rtl/shv_ifs.sv @@
// Channel interfaces of the RGB shade core.
`default_nettype none
interface shv_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  modport source(output valid, red_in, green_in, blue_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface

interface shv_shd_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  modport source(output valid, red_out, green_out, blue_out, input ready);
  modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface

interface shv_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/shv_front.sv @@
// Front stage: accepts colours and classifies them into division jobs.
`default_nettype none
module shv_front import shv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  shv_pix_if.sink  pix,
  input  logic     q_full,
  output logic     push,
  output cls_t     push_rec
);

  localparam logic [UNIT_W:0] TWO_Q = (UNIT_W + 1)'(2 << FRAC_BITS);

  logic              fv;
  cls_t              rec;
  cls_t              rec_next;
  logic [UNIT_W-1:0] r, g, b, mx, mn, delta, mag;
  logic [UNIT_W:0]   sum;
  logic signed [UNIT_W:0] num;
  logic [21:0]       m60;

  function automatic logic [UNIT_W-1:0] to_unit(input logic [CH_W-1:0] v);
    return {1'b0, v} + {{(UNIT_W-1){1'b0}}, &v};
  endfunction

  always_comb begin
    r = to_unit(pix.red_in);
    g = to_unit(pix.green_in);
    b = to_unit(pix.blue_in);
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum   = {1'b0, mx} + {1'b0, mn};
    delta = mx - mn;
    rec_next.l    = sum[UNIT_W:1];
    rec_next.grey = (mx == mn);
    if (sum[UNIT_W:1] <= HALF_Q) begin
      rec_next.sdiv = sum[UNIT_W-1:0];
    end else begin
      rec_next.sdiv = UNIT_W'(TWO_Q - sum);
    end
    if (r == mx) begin
      rec_next.sector = SEC_RED;
      num = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (g == mx) begin
      rec_next.sector = SEC_GREEN;
      num = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      rec_next.sector = SEC_BLUE;
      num = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    rec_next.neg  = num[UNIT_W];
    mag           = num[UNIT_W] ? UNIT_W'(-num) : num[UNIT_W-1:0];
    m60           = 22'(mag) * 22'd60;
    rec_next.hnum = {m60, {FRAC_BITS{1'b0}}};
    rec_next.hdiv = delta;
    rec_next.snum = {5'b0, delta, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (pix.valid && pix.ready) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.valid && pix.ready) begin
      rec <= rec_next;
    end
  end

  assign push      = fv && !q_full;
  assign push_rec  = rec;
  assign pix.ready = !fv || !q_full;

endmodule
`default_nettype wire

@@ hw/rtl/shv_queue.sv @@
// Short queue of classified jobs between the front and back parts.
`default_nettype none
module shv_queue import shv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_rec,
  output logic full,
  input  logic pop,
  output logic valid,
  output cls_t head
);

  cls_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QCNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  assign full  = (cnt == QCNT_W'(QDEPTH));
  assign valid = (cnt != '0);
  assign head  = mem[rp];

endmodule
`default_nettype wire

@@ hw/rtl/shv_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, two lanes.
`default_nettype none
module shv_div import shv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  cls_t  rec,
  output logic  pop,
  output logic  out_valid,
  output dres_t res
);

  typedef struct packed {
    logic [UNIT_W-1:0] rem;
    logic [QUO_W-1:0]  wd;
  } dlane_t;

  typedef struct packed {
    logic [UNIT_W-1:0] l;
    logic              grey;
    logic [1:0]        sector;
    logic              neg;
    logic [UNIT_W-1:0] hdiv;
    logic [UNIT_W-1:0] sdiv;
  } side_t;

  logic [DIV_STEPS-1:0] v_q;
  dlane_t hl_q [DIV_STEPS];
  dlane_t sl_q [DIV_STEPS];
  dlane_t hl_d [DIV_STEPS];
  dlane_t sl_d [DIV_STEPS];
  side_t  sb_q [DIV_STEPS];
  dlane_t hl0, sl0;
  side_t  side0;

  function automatic dlane_t div_step(input dlane_t x, input logic [UNIT_W-1:0] d);
    logic [UNIT_W:0] t;
    logic            ge;
    dlane_t          y;
    t     = {x.rem, x.wd[QUO_W-1]};
    ge    = (t >= {1'b0, d});
    y.rem = ge ? UNIT_W'(t - {1'b0, d}) : t[UNIT_W-1:0];
    y.wd  = {x.wd[QUO_W-2:0], ge};
    return y;
  endfunction

  always_comb begin
    hl0.rem      = UNIT_W'(rec.hnum[NUM_W-1:QUO_W]);
    hl0.wd       = rec.hnum[QUO_W-1:0];
    sl0.rem      = UNIT_W'(rec.snum[NUM_W-1:QUO_W]);
    sl0.wd       = rec.snum[QUO_W-1:0];
    side0.l      = rec.l;
    side0.grey   = rec.grey;
    side0.sector = rec.sector;
    side0.neg    = rec.neg;
    side0.hdiv   = rec.hdiv;
    side0.sdiv   = rec.sdiv;
    hl_d[0] = div_step(hl0, side0.hdiv);
    sl_d[0] = div_step(sl0, side0.sdiv);
    for (int k = 1; k < DIV_STEPS; k++) begin
      hl_d[k] = div_step(hl_q[k-1], sb_q[k-1].hdiv);
      sl_d[k] = div_step(sl_q[k-1], sb_q[k-1].sdiv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_q[0] <= side0;
      for (int k = 1; k < DIV_STEPS; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        hl_q[k] <= hl_d[k];
        sl_q[k] <= sl_d[k];
      end
    end
  end

  assign pop        = adv && in_valid;
  assign out_valid  = v_q[DIV_STEPS-1];
  assign res.l      = sb_q[DIV_STEPS-1].l;
  assign res.grey   = sb_q[DIV_STEPS-1].grey;
  assign res.sector = sb_q[DIV_STEPS-1].sector;
  assign res.neg    = sb_q[DIV_STEPS-1].neg;
  assign res.sq     = sl_q[DIV_STEPS-1].wd;
  assign res.hq     = hl_q[DIV_STEPS-1].wd;

endmodule
`default_nettype wire

@@ hw/rtl/shv_conv.sv @@
// Back end: shading, conversion back to RGB and the output register.
`default_nettype none
module shv_conv import shv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  dres_t              res,
  input  logic [SHADE_W-1:0] shade_factor,
  output logic               adv,
  shv_shd_if.source          shaded
);

  localparam logic [1:0] SEG_RISE = 2'd0;
  localparam logic [1:0] SEG_TOP  = 2'd1;
  localparam logic [1:0] SEG_FALL = 2'd2;
  localparam logic [1:0] SEG_LOW  = 2'd3;

  // Stage A: shaded lightness, saturation and hue.
  logic                 va;
  logic [UNIT_W-1:0]    la, sa;
  logic [HUE_W-1:0]     ha;
  logic [UNIT_W-1:0]    s_raw, l_sh, s_sh;
  logic [32:0]          lp, sp;
  logic [HUE_W-1:0]     base;
  logic signed [26:0]   hs;

  always_comb begin
    s_raw = res.grey ? '0 : res.sq[UNIT_W-1:0];
    lp    = 33'(res.l) * 33'(shade_factor);
    sp    = 33'(s_raw) * 33'(shade_factor);
    l_sh  = (lp[32:SHADE_FRAC] > 21'(ONE_Q)) ? ONE_Q : lp[SHADE_FRAC+UNIT_W-1:SHADE_FRAC];
    s_sh  = (sp[32:SHADE_FRAC] > 21'(ONE_Q)) ? ONE_Q : sp[SHADE_FRAC+UNIT_W-1:SHADE_FRAC];
    case (res.sector)
      SEC_GREEN: base = DEG_120;
      SEC_BLUE:  base = DEG_240;
      default:   base = '0;
    endcase
    if (res.neg) begin
      hs = $signed({2'b00, base}) - $signed({5'b0, res.hq});
    end else begin
      hs = $signed({2'b00, base}) + $signed({5'b0, res.hq});
    end
    if (hs < 0) hs = hs + $signed({2'b00, DEG_360});
  end

  // Stage B: the two levels of the colour and the three channel hues.
  logic                 vb, zb;
  logic signed [19:0]   m1b;
  logic [UNIT_W-1:0]    m2b, lb;
  logic [HUE_W-1:0]     hue_b [3];
  logic [33:0]          pls;
  logic [17:0]          ph;
  logic [18:0]          m2;
  logic [HUE_W-1:0]     hr, hb;

  always_comb begin
    pls = 34'(la) * 34'(sa);
    ph  = pls[33:FRAC_BITS];
    if (la <= HALF_Q) begin
      m2 = 19'(la) + 19'(ph);
    end else begin
      m2 = 19'(la) + 19'(sa) - 19'(ph);
    end
    hr = ha + DEG_120;
    if (hr > DEG_360) hr = hr - DEG_360;
    if (ha >= DEG_120) begin
      hb = ha - DEG_120;
    end else begin
      hb = ha + DEG_240;
    end
  end

  // Stage C: span times hue offset for each channel.
  logic                 vc, zc;
  logic signed [19:0]   m1c;
  logic [UNIT_W-1:0]    m2c, lc;
  logic [38:0]          prod_c [3];
  logic [1:0]           code_c [3];
  logic [38:0]          prod_n [3];
  logic [1:0]           code_n [3];
  logic signed [20:0]   span;
  logic [UNIT_W-1:0]    span_c;
  logic [21:0]          fac;

  always_comb begin
    span = $signed({4'b0, m2b}) - 21'(m1b);
    span_c = (span < 0) ? '0 : span[UNIT_W-1:0];
    for (int i = 0; i < 3; i++) begin
      if (hue_b[i] < DEG_60) begin
        code_n[i] = SEG_RISE;
        fac       = hue_b[i][21:0];
      end else if (hue_b[i] < DEG_180) begin
        code_n[i] = SEG_TOP;
        fac       = '0;
      end else if (hue_b[i] < DEG_240) begin
        code_n[i] = SEG_FALL;
        fac       = 22'(DEG_240 - hue_b[i]);
      end else begin
        code_n[i] = SEG_LOW;
        fac       = '0;
      end
      prod_n[i] = 39'(span_c) * 39'(fac);
    end
  end

  // Stage D: division by sixty degrees and selection of the level.
  logic                 vd;
  logic signed [20:0]   cd [3];
  logic signed [20:0]   cd_n [3];
  logic [42:0]          qq;
  logic [17:0]          q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qq = 43'(prod_c[i][38:FRAC_BITS+2]) * 43'(RECIP_15);
      q  = qq[RECIP_SH+17:RECIP_SH];
      case (code_c[i])
        SEG_RISE, SEG_FALL: cd_n[i] = 21'(m1c) + $signed({3'b0, q});
        SEG_TOP:            cd_n[i] = $signed({4'b0, m2c});
        default:            cd_n[i] = 21'(m1c);
      endcase
      if (zc) cd_n[i] = $signed({4'b0, lc});
    end
  end

  // Stage E: clamp to the unit range and scale to sixteen bits.
  logic               ve;
  logic [CH_W-1:0]    w_n [3];
  logic [UNIT_W-1:0]  cl;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cd[i] < 0) begin
        cl = '0;
      end else if (cd[i] > $signed({4'b0, ONE_Q})) begin
        cl = ONE_Q;
      end else begin
        cl = cd[i][UNIT_W-1:0];
      end
      w_n[i] = (cl == '0) ? '0 : CH_W'(cl - 1'b1);
    end
  end

  assign adv = !ve || shaded.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      la <= l_sh;
      sa <= s_sh;
      ha <= res.grey ? '0 : hs[HUE_W-1:0];
      m1b <= $signed({1'b0, la, 1'b0}) - $signed({1'b0, m2});
      m2b <= m2[UNIT_W-1:0];
      lb  <= la;
      zb  <= (sa == '0);
      hue_b[0] <= hr;
      hue_b[1] <= ha;
      hue_b[2] <= hb;
      m1c <= m1b;
      m2c <= m2b;
      lc  <= lb;
      zc  <= zb;
      for (int i = 0; i < 3; i++) begin
        prod_c[i] <= prod_n[i];
        code_c[i] <= code_n[i];
        cd[i]     <= cd_n[i];
      end
      shaded.red_out   <= w_n[0];
      shaded.green_out <= w_n[1];
      shaded.blue_out  <= w_n[2];
    end
  end

  assign shaded.valid = ve;

endmodule
`default_nettype wire

@@ hw/rtl/rgb_shade_via_hls_core.sv @@
// Top level of the RGB shade core through hue, lightness and saturation.
//
// The core takes one 16-bit-per-channel colour per transaction on pix, turns
// it into hue, lightness and saturation in fixed point, multiplies lightness
// and saturation by the shade factor (unsigned Q4.12, 1.0 after reset) with
// a clamp at 1.0, and returns the shaded colour on shaded, one result per
// input, in order. It takes one colour per clock cycle as long as shaded is
// drained. The accepting edge loads the classifying front stage, the job then
// moves into the four-entry job queue, through the restoring divider that
// produces one quotient bit per stage for both saturation and hue, and on
// through the shading and back-conversion stages that end in the output
// register. When shaded stalls, the back pipeline holds still; the queue and
// the front stage then absorb up to five further colours before pix drops
// ready. The shade factor is written by a transaction on cfg, which is always
// ready; it should only be changed while no colour is in flight.
`default_nettype none
module rgb_shade_via_hls_core import shv_pkg::*; (
  input logic       clk,
  input logic       rst,
  shv_pix_if.sink   pix,
  shv_shd_if.source shaded,
  shv_cfg_if.sink   cfg
);

  logic [SHADE_W-1:0] shade_factor;
  logic               push, q_full, pop, q_valid, adv, d_valid;
  cls_t               push_rec, q_head;
  dres_t              d_res;

  // The shade factor register; the write channel never stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      shade_factor <= SHADE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      shade_factor <= cfg.data;
    end
  end

  assign cfg.ready = 1'b1;

  // Front: normalises the channels, finds maximum and minimum, and sets up
  // the dividends and divisors for saturation and hue.
  shv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  // The queue decouples the front from the stall-all back pipeline.
  shv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Both divisions run side by side, one quotient bit per stage.
  shv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (q_valid),
    .rec       (q_head),
    .pop       (pop),
    .out_valid (d_valid),
    .res       (d_res)
  );

  // Shading, conversion back to RGB and the output register; adv tells the
  // whole back pipeline whether it may move on this cycle.
  shv_conv u_conv (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (d_valid),
    .res          (d_res),
    .shade_factor (shade_factor),
    .adv          (adv),
    .shaded       (shaded)
  );

endmodule
`default_nettype wire

@@ hw/rtl/shv_checker.sv @@
// Port-level checker of the RGB shade core and its bind statement.
`default_nettype none
`include "rgb_shade_via_hls_core_assert.svh"
module shv_checker (
  input logic        clk,
  input logic        rst,
  input logic        pix_ready,
  input logic        shaded_valid,
  input logic        shaded_ready,
  input logic [15:0] red_out,
  input logic [15:0] green_out,
  input logic [15:0] blue_out
);

  // No result is offered straight after reset.
  `SHV_ASSERT_AFTER_RST(a_rst_clears_out, clk, rst, !shaded_valid)

  // A stalled result stays on offer unchanged.
  `SHV_ASSERT_NEXT(a_out_hold, clk, rst, shaded_valid && !shaded_ready, shaded_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out))

  // The input only stalls once the output has been held up the cycle before.
  `SHV_ASSERT_NOW(a_in_stall_cause, clk, rst, !pix_ready, $past(shaded_valid && !shaded_ready))

endmodule

bind rgb_shade_via_hls_core shv_checker u_shv_checker (
  .clk          (clk),
  .rst          (rst),
  .pix_ready    (pix.ready),
  .shaded_valid (shaded.valid),
  .shaded_ready (shaded.ready),
  .red_out      (shaded.red_out),
  .green_out    (shaded.green_out),
  .blue_out     (shaded.blue_out)
);
`default_nettype wire
